FILE: rtl/m6502_pkg.sv
// Shared types and constants for the 6502 subset core.
package m6502_pkg;

    // Item operation codes
    localparam logic [1:0] ITEM_TICK    = 2'd0;
    localparam logic [1:0] ITEM_WRITE   = 2'd1;
    localparam logic [1:0] ITEM_READ    = 2'd2;
    localparam logic [1:0] ITEM_RESTART = 2'd3;

    // Supported opcodes
    localparam logic [7:0] OPC_JSR     = 8'h20;
    localparam logic [7:0] OPC_PHA     = 8'h48;
    localparam logic [7:0] OPC_JMP     = 8'h4C;
    localparam logic [7:0] OPC_ROR     = 8'h6A;
    localparam logic [7:0] OPC_STA     = 8'h8D;
    localparam logic [7:0] OPC_TXS     = 8'h9A;
    localparam logic [7:0] OPC_LDX     = 8'hA2;
    localparam logic [7:0] OPC_LDA     = 8'hA9;
    localparam logic [7:0] OPC_LDA_ABS = 8'hAD;
    localparam logic [7:0] OPC_NOP     = 8'hEA;

    localparam logic [7:0]  FLAG_N      = 8'h80;
    localparam logic [7:0]  FLAG_Z      = 8'h02;
    localparam logic [7:0]  FLAG_C      = 8'h01;
    localparam logic [7:0]  RESET_FLAGS = 8'h36;
    localparam logic [15:0] STACK_BASE  = 16'h0100;
    localparam logic [7:0]  VEC_LO      = 8'hFC;
    localparam logic [7:0]  VEC_HI      = 8'hFD;
    localparam logic [15:0] HIGH_PAGE   = 16'hFF00;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_HALT  = 2'd2
    } run_mode_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] program_counter;
        logic [7:0]  accumulator;
        logic [7:0]  index_x;
        logic [7:0]  stack_pointer;
        logic [7:0]  status_flags;
        logic [1:0]  run_mode;
        logic [7:0]  current_opcode;
    } out_item_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  sp;
        logic [7:0]  flags;
        logic [7:0]  opcode;
        logic [15:0] addr_latch;
        logic [3:0]  stage;
        run_mode_t   mode;
    } cpu_state_t;

    typedef struct packed {
        logic        wr_en;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

endpackage

FILE: rtl/m6502_exec.sv
// Decode of the memory access for an item and the register update after it.
module m6502_exec import m6502_pkg::*; (
    input  cpu_state_t state,
    input  in_item_t   issue_item,
    input  in_item_t   exec_item,
    input  logic [7:0] mem_rdata,
    output mem_req_t   mem_req,
    output cpu_state_t state_next,
    output out_item_t  result
);

    function automatic logic [7:0] with_nz(input logic [7:0] flags, input logic [7:0] v);
        logic [7:0] f;
        f = flags & ~(FLAG_N | FLAG_Z);
        if (v == 8'd0) f = f | FLAG_Z;
        if (v[7]) f = f | FLAG_N;
        return f;
    endfunction

    logic [15:0] ret_addr;
    logic [15:0] stack_addr;
    logic [15:0] pc_inc;
    logic [3:0]  stage_inc;
    logic [7:0]  ror_val;

    assign ret_addr   = state.pc + 16'd2;
    assign stack_addr = STACK_BASE + {8'd0, state.sp};
    assign pc_inc     = state.pc + 16'd1;
    assign stage_inc  = state.stage + 4'd1;
    assign ror_val    = {state.flags[0], state.acc[7:1]};

    // Memory request of the issue cycle; default address is the fetch address
    always_comb begin
        mem_req.wr_en = 1'b0;
        mem_req.addr  = state.pc;
        mem_req.wdata = state.acc;
        case (issue_item.operation)
            ITEM_WRITE: begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = issue_item.address;
                mem_req.wdata = issue_item.write_data;
            end
            ITEM_READ: begin
                mem_req.addr = issue_item.address;
            end
            ITEM_TICK: begin
                if (state.mode == MODE_RESET) begin
                    mem_req.addr = state.addr_latch;
                end else if (state.mode == MODE_RUN) begin
                    case (state.stage)
                        4'd1: begin
                            if (state.opcode == OPC_JSR) begin
                                mem_req.wr_en = 1'b1;
                                mem_req.addr  = stack_addr;
                                mem_req.wdata = ret_addr[15:8];
                            end else if (state.opcode == OPC_PHA) begin
                                mem_req.wr_en = 1'b1;
                                mem_req.addr  = stack_addr;
                            end
                        end
                        4'd2: begin
                            if (state.opcode == OPC_JSR) begin
                                mem_req.wr_en = 1'b1;
                                mem_req.addr  = stack_addr;
                                mem_req.wdata = ret_addr[7:0];
                            end
                        end
                        4'd3: begin
                            if (state.opcode == OPC_STA) begin
                                mem_req.wr_en = 1'b1;
                                mem_req.addr  = state.addr_latch;
                            end else if (state.opcode == OPC_LDA_ABS) begin
                                mem_req.addr = state.addr_latch;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Register update of the execute cycle
    always_comb begin
        state_next = state;
        case (exec_item.operation)
            ITEM_TICK: begin
                case (state.mode)
                    MODE_RESET: begin
                        state_next.stage = stage_inc;
                        case (state.stage)
                            4'd0: state_next.flags = RESET_FLAGS;
                            4'd1: state_next.addr_latch = {state.addr_latch[15:8], VEC_LO};
                            4'd2: state_next.addr_latch = state.addr_latch | HIGH_PAGE;
                            4'd3: state_next.acc = mem_rdata;
                            4'd4: state_next.pc = {state.pc[15:8], state.acc};
                            4'd5: state_next.addr_latch = {state.addr_latch[15:8], VEC_HI};
                            4'd6: state_next.addr_latch = state.addr_latch | HIGH_PAGE;
                            4'd7: state_next.acc = mem_rdata;
                            4'd8: begin
                                state_next.pc    = {state.acc, state.pc[7:0]};
                                state_next.mode  = MODE_RUN;
                                state_next.stage = 4'd0;
                            end
                            default: ;
                        endcase
                    end
                    MODE_RUN: begin
                        state_next.stage = stage_inc;
                        case (state.stage)
                            4'd0: begin
                                state_next.opcode = mem_rdata;
                                state_next.pc     = pc_inc;
                            end
                            4'd1: begin
                                if (state.opcode == OPC_JSR || state.opcode == OPC_PHA) begin
                                    state_next.sp = state.sp - 8'd1;
                                end else if (state.opcode == OPC_ROR) begin
                                    state_next.acc   = ror_val;
                                    state_next.flags = (with_nz(state.flags, ror_val) & ~FLAG_C)
                                                     | {7'd0, state.acc[0]};
                                    state_next.stage = 4'd0;
                                end else if (state.opcode inside {OPC_JMP, OPC_STA, OPC_LDA_ABS})
                                begin
                                    state_next.addr_latch = {state.addr_latch[15:8], mem_rdata};
                                    state_next.pc         = pc_inc;
                                end else if (state.opcode == OPC_TXS) begin
                                    state_next.sp    = state.x;
                                    state_next.stage = 4'd0;
                                end else if (state.opcode == OPC_LDX) begin
                                    state_next.x     = mem_rdata;
                                    state_next.flags = with_nz(state.flags, mem_rdata);
                                    state_next.pc    = pc_inc;
                                    state_next.stage = 4'd0;
                                end else if (state.opcode == OPC_LDA) begin
                                    state_next.acc   = mem_rdata;
                                    state_next.flags = with_nz(state.flags, mem_rdata);
                                    state_next.pc    = pc_inc;
                                    state_next.stage = 4'd0;
                                end else if (state.opcode == OPC_NOP) begin
                                    state_next.stage = 4'd0;
                                end else begin
                                    state_next.mode = MODE_HALT;
                                end
                            end
                            4'd2: begin
                                if (state.opcode == OPC_JSR) begin
                                    state_next.sp = state.sp - 8'd1;
                                end else if (state.opcode == OPC_PHA) begin
                                    state_next.stage = 4'd0;
                                end else if (state.opcode inside {OPC_JMP, OPC_STA, OPC_LDA_ABS})
                                begin
                                    state_next.addr_latch = {mem_rdata, state.addr_latch[7:0]};
                                    state_next.pc         = pc_inc;
                                end else begin
                                    state_next.mode = MODE_HALT;
                                end
                            end
                            4'd3: begin
                                if (state.opcode == OPC_JSR) begin
                                    state_next.addr_latch = {state.addr_latch[15:8], mem_rdata};
                                    state_next.pc         = pc_inc;
                                end else if (state.opcode == OPC_JMP) begin
                                    state_next.pc    = state.addr_latch;
                                    state_next.stage = 4'd0;
                                end else if (state.opcode == OPC_STA) begin
                                    state_next.stage = 4'd0;
                                end else if (state.opcode == OPC_LDA_ABS) begin
                                    state_next.acc   = mem_rdata;
                                    state_next.flags = with_nz(state.flags, mem_rdata);
                                    state_next.stage = 4'd0;
                                end else begin
                                    state_next.mode = MODE_HALT;
                                end
                            end
                            4'd4: begin
                                if (state.opcode == OPC_JSR) begin
                                    state_next.addr_latch = {mem_rdata, state.addr_latch[7:0]};
                                    state_next.pc         = pc_inc;
                                end else begin
                                    state_next.mode = MODE_HALT;
                                end
                            end
                            4'd5: begin
                                if (state.opcode == OPC_JSR) begin
                                    state_next.pc    = state.addr_latch;
                                    state_next.stage = 4'd0;
                                end else begin
                                    state_next.mode = MODE_HALT;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            ITEM_RESTART: begin
                state_next.mode  = MODE_RESET;
                state_next.stage = 4'd0;
            end
            default: ;
        endcase
    end

    always_comb begin
        result.read_data       = (exec_item.operation == ITEM_READ) ? mem_rdata : 8'd0;
        result.program_counter = state_next.pc;
        result.accumulator     = state_next.acc;
        result.index_x         = state_next.x;
        result.stack_pointer   = state_next.sp;
        result.status_flags    = state_next.flags;
        result.run_mode        = state_next.mode;
        result.current_opcode  = state_next.opcode;
    end

endmodule

FILE: rtl/mini_6502_subset_core.sv
// Top level of the 6502 subset core: memory, item handshake and register file.
//
//  Channel  Ports                        Carries
//  -------  ---------------------------  ---------------------------------------------
//  input    s_valid / s_ready / s_data   tick, memory write, memory read or restart
//  result   m_valid / m_ready / m_data   read byte plus register snapshot after the step
//
// Per transaction, the accept cycle issues the one memory access of the item
// (write, or read of the synchronous memory); the execute cycle, once the result register
// is free, takes the read data, updates the registers and loads the result register. A new
// transaction can be accepted in the cycle after that.
// Reset: aresetn low clears the registers, the stage count and both valid flags; the core
// comes up in the reset sequence. Memory contents are not cleared.
// Stalls: a waiting result does not block input; one item is held in the execute stage
// until the result register frees up, and input stalls whenever the execute stage holds an item.
module mini_6502_subset_core import m6502_pkg::*; #(
    parameter int MEM_DEPTH = 65536
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int ADDR_W = $clog2(MEM_DEPTH);

    // Main memory, one access per transaction
    logic [7:0] mem_array [MEM_DEPTH];
    logic [7:0] rdata_reg;

    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    in_item_t   item_reg;
    out_item_t  out_reg;
    cpu_state_t state_reg, state_next;

    mem_req_t   mem_req;
    out_item_t  result;
    logic       accept;
    logic       retire;

    // Accept when the execute stage is empty; retire when the result slot frees up
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign retire  = busy_reg && (!out_valid_reg || m_ready);

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    m6502_exec u_exec (
        .state      (state_reg),
        .issue_item (s_data),
        .exec_item  (item_reg),
        .mem_rdata  (rdata_reg),
        .mem_req    (mem_req),
        .state_next (state_next),
        .result     (result)
    );

    // Drive memory only on the accept cycle; registers are stable until the item retires
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (mem_req.wr_en) begin
                mem_array[mem_req.addr[ADDR_W-1:0]] <= mem_req.wdata;
            end else begin
                rdata_reg <= mem_array[mem_req.addr[ADDR_W-1:0]];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (retire) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (retire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (retire) begin
                state_reg <= state_next;
            end
        end
    end

    // Hold the item for the execute cycle and the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (retire) begin
            out_reg <= result;
        end
    end

    // A memory write happens only while a transaction is being accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mem_req.wr_en) |-> (busy_reg == 1'b0))
        else $error("memory write outside accept cycle");

    // An accepted item always occupies the execute stage in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg)
        else $error("accepted item lost");

    // A retiring item always leaves a valid result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        retire |=> (m_valid && !busy_reg))
        else $error("retired item produced no result");

    // The running core never passes the last JSR stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_RUN) |-> (state_reg.stage < 4'd6))
        else $error("run stage out of range");

    // A tick in halted mode leaves every register untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (retire && state_reg.mode == MODE_HALT && item_reg.operation == ITEM_TICK)
        |=> $stable(state_reg))
        else $error("halted core changed state");

endmodule
